[rtl/fpr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the framed packet receiver.
// Has no dependencies; every other file in rtl/ imports it.
package fpr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DropW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] HeadByteReset  = 8'hCC;
  localparam logic [ByteW-1:0] TailByteReset  = 8'hB9;
  localparam logic [ByteW-1:0] MaxLengthReset = 8'd128;
  localparam logic [ByteW-1:0] ByteCr         = 8'h0D;
  localparam logic [ByteW-1:0] ByteLf         = 8'h0A;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgHeadByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTailByte  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxLength = 2'd2;

  // Request kinds.
  localparam logic KindByte    = 1'b0;
  localparam logic KindRestart = 1'b1;

  // Drop reason codes.
  localparam logic [DropW-1:0] DropNone   = 3'd0;
  localparam logic [DropW-1:0] DropLength = 3'd1;
  localparam logic [DropW-1:0] DropTail   = 3'd2;
  localparam logic [DropW-1:0] DropSum    = 3'd3;
  localparam logic [DropW-1:0] DropCr     = 3'd4;
  localparam logic [DropW-1:0] DropLf     = 3'd5;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_TAIL    = 3'd3,
    PH_CHECK   = 3'd4,
    PH_CR      = 3'd5,
    PH_LF      = 3'd6
  } phase_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic             packet_done;
    logic [ByteW-1:0] packet_id;
    logic [ByteW-1:0] packet_length;
    logic [DropW-1:0] drop_code;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] head_byte;
    logic [ByteW-1:0] tail_byte;
    logic [ByteW-1:0] max_length;
  } cfg_t;

  // Checksum step: rotate right by one bit, then add the byte modulo 256.
  function automatic logic [ByteW-1:0] sum_step(input logic [ByteW-1:0] sum,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] rot;
    rot = {sum[0], sum[ByteW-1:1]};
    return rot + b;
  endfunction

endpackage

[rtl/framed_packet_receiver_top.sv]
`timescale 1ns / 1ps
// Framed packet receiver: top level with the configuration registers.
// Depends on fpr_pkg, fpr_in_reg, fpr_parser and fpr_out_reg.
//
// Usage: each input request carries one received serial byte (kind byte) or a
// restart (kind restart). Frames are head byte, length, payload (first byte is
// the message ID), tail byte, checksum, CR, LF. Every request yields exactly
// one result request, in order: a payload byte with its index, a finished
// packet with ID and length on LF, a drop reason code, or all zeros.
// Both channels hand over a request when valid is high and stall is low.
// The result is registered: an accepted request passes from the input register
// into the result register, where it shows on out_valid; throughput is one
// request per cycle while the receiver does not stall, set by the single parser
// state update between the input register and the result register.
// The input side keeps accepting while a finished result waits downstream,
// as long as the input register is free or its request moves on that cycle;
// when the receiver stalls, the result holds and in_stall rises only once
// both the result and input registers are occupied.
// Reset (rst, synchronous) empties both registers, returns the parser to the
// head search with a cleared checksum, count, length and ID, and loads the
// configuration registers with head 0xCC, tail 0xB9 and maximum length 128.
// Configuration writes are expected only while the block is idle.
module framed_packet_receiver_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fpr_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fpr_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [fpr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fpr_pkg::ByteW-1:0]    cfg_wdata
);
  import fpr_pkg::*;

  cfg_t      cfg;
  logic      held_valid;
  in_item_t  held_data;
  logic      take;
  out_item_t res;

  // Configuration registers; an index beyond the list writes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte  <= HeadByteReset;
      cfg.tail_byte  <= TailByteReset;
      cfg.max_length <= MaxLengthReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgHeadByte:  cfg.head_byte  <= cfg_wdata;
        CfgTailByte:  cfg.tail_byte  <= cfg_wdata;
        CfgMaxLength: cfg.max_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: holds the accepted request until the parser consumes it.
  fpr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .held_valid (held_valid),
    .held_data  (held_data),
    .take       (take)
  );

  // Parser: the state advances exactly when a request moves into the result
  // register, so every request updates the state once.
  fpr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (held_data),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register facing the downstream receiver.
  fpr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res        (res),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[rtl/fpr_in_reg.sv]
`timescale 1ns / 1ps
// Input register stage of the framed packet receiver.
// Depends on fpr_pkg for the request type.
module fpr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fpr_pkg::in_item_t in_data,
  output logic              held_valid,
  output fpr_pkg::in_item_t held_data,
  input  logic              take
);
  import fpr_pkg::*;

  logic load;

  // The register can load whenever it is empty or its request leaves this cycle.
  assign in_stall = held_valid && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_data <= in_data;
    end
  end

endmodule

[rtl/fpr_parser.sv]
`timescale 1ns / 1ps
// Frame parser state and per-byte result logic.
// Depends on fpr_pkg for the phase type, codes and checksum step.
module fpr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  fpr_pkg::in_item_t  item,
  input  fpr_pkg::cfg_t      cfg,
  output fpr_pkg::out_item_t res
);
  import fpr_pkg::*;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] byte_count, byte_count_next;
  logic [ByteW-1:0] expected_length, expected_length_next;
  logic [ByteW-1:0] running_sum, running_sum_next;
  logic [ByteW-1:0] held_id, held_id_next;
  logic [ByteW-1:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEAD;
      byte_count      <= '0;
      expected_length <= '0;
      running_sum     <= '0;
      held_id         <= '0;
    end else if (take) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      running_sum     <= running_sum_next;
      held_id         <= held_id_next;
    end
  end

  assign count_inc = byte_count + 8'd1;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    held_id_next         = held_id;
    res                  = '0;
    if (item.kind == KindRestart) begin
      phase_next           = PH_HEAD;
      byte_count_next      = '0;
      expected_length_next = '0;
      running_sum_next     = '0;
      held_id_next         = '0;
    end else begin
      case (phase)
        PH_LEN: begin
          expected_length_next = item.rx_byte;
          byte_count_next      = '0;
          running_sum_next     = '0;
          if (item.rx_byte == '0 || item.rx_byte > cfg.max_length) begin
            phase_next    = PH_HEAD;
            res.drop_code = DropLength;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (byte_count == '0) begin
            held_id_next = item.rx_byte;
          end
          running_sum_next  = sum_step(running_sum, item.rx_byte);
          res.payload_valid = 1'b1;
          res.payload_byte  = item.rx_byte;
          res.payload_index = byte_count;
          byte_count_next   = count_inc;
          if (count_inc >= expected_length) begin
            phase_next = PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (item.rx_byte == cfg.tail_byte) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next    = PH_HEAD;
            res.drop_code = DropTail;
          end
        end
        PH_CHECK: begin
          if (item.rx_byte == running_sum) begin
            phase_next = PH_CR;
          end else begin
            phase_next    = PH_HEAD;
            res.drop_code = DropSum;
          end
        end
        PH_CR: begin
          if (item.rx_byte == ByteCr) begin
            phase_next = PH_LF;
          end else begin
            phase_next    = PH_HEAD;
            res.drop_code = DropCr;
          end
        end
        PH_LF: begin
          phase_next = PH_HEAD;
          if (item.rx_byte == ByteLf) begin
            res.packet_done   = 1'b1;
            res.packet_id     = held_id;
            res.packet_length = expected_length;
          end else begin
            res.drop_code = DropLf;
          end
        end
        default: begin
          phase_next = (item.rx_byte == cfg.head_byte) ? PH_LEN : PH_HEAD;
        end
      endcase
    end
  end

  // A restart always returns the parser to the head search.
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.kind == KindRestart |=> phase == PH_HEAD && byte_count == '0)
    else $error("restart did not clear the parser");

  // Payload bytes are only produced inside the payload phase.
  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    res.payload_valid |-> phase == PH_PAYLOAD && item.kind == KindByte)
    else $error("payload byte outside the payload phase");

  // A finished packet never also carries a drop reason.
  a_done_no_drop: assert property (@(posedge clk) disable iff (rst)
    res.packet_done |-> res.drop_code == DropNone && phase == PH_LF)
    else $error("packet done with a drop reason");

  // Once the payload phase is entered, at least one byte is expected.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> expected_length != '0)
    else $error("payload phase with zero length");

endmodule

[rtl/fpr_out_reg.sv]
`timescale 1ns / 1ps
// Result register stage of the framed packet receiver.
// Depends on fpr_pkg for the result type.
module fpr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               held_valid,
  input  fpr_pkg::out_item_t res,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output fpr_pkg::out_item_t out_data
);
  import fpr_pkg::*;

  logic can_load;

  // The register takes a new result when it is empty or its result leaves now.
  assign can_load = !out_valid || !out_stall;
  assign take     = held_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res;
    end
  end

endmodule
